/* rtl/content_keyed_slot_allocator_core_defines.svh */
// assertion macros shared by the slot allocator rtl
`ifndef CONTENT_KEYED_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define CONTENT_KEYED_SLOT_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTH

// checked property, off while reset is held
`define CKSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked property, also during reset
`define CKSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CKSA_ASSERT(lbl, clk, rst_n, prop, msg)

`define CKSA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/cksa_pkg.sv */
// types and constants of the content keyed slot allocator
`default_nettype none

package cksa_pkg;

  localparam int unsigned SECTOR_BYTES = 4096;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_MARK   = 2'd2,
    CMD_SWEEP  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    STAT_FOUND       = 4'd0,
    STAT_NOT_FOUND   = 4'd1,
    STAT_INSERTED    = 4'd2,
    STAT_PRESENT     = 4'd3,
    STAT_INVALID     = 4'd4,
    STAT_FULL        = 4'd5,
    STAT_MARKED      = 4'd6,
    STAT_SWEPT_FREED = 4'd7,
    STAT_SWEPT_NONE  = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_SCAN  = 3'd2,
    ST_FIN   = 3'd3,
    ST_MUL   = 3'd4,
    ST_DONE  = 3'd5
  } state_t;

  // one slot table entry; size zero means free
  typedef struct packed {
    logic [31:0] key;
    logic [15:0] size;
    logic        mark;
  } slot_entry_t;

endpackage

`default_nettype wire

/* rtl/content_keyed_slot_allocator_core.sv */
// top level of the content keyed slot allocator: slot table, scan sequencer, result register
`default_nettype none
`include "content_keyed_slot_allocator_core_defines.svh"
//
// usage
// - input channel in_valid / in_stall carries cmd, key and item_size; a transfer
//   happens at a clock edge with in_valid high and in_stall low
// - commands: lookup, insert (dedup or lowest free slot), mark key live, sweep
// - result channel out_valid / out_stall carries one result per command
// - every command walks the whole slot table through one read port and one key
//   comparator, one slot per cycle, then passes a finish step and a multiply
//   step before its result; an invalid insert skips the walk
// - in_stall is high from a transfer until the result is loaded into the output
//   register; a new item may be taken while that result still waits
// - when the receiver stalls, the result holds in the output register and the
//   next command finishes its walk, then waits for the register to empty
// - after reset a clearing pass writes every slot free and unmarked while
//   in_stall is high
// - slot address is pool base plus slot index times slot capacity (one multiply)
//
module content_keyed_slot_allocator_core
  import cksa_pkg::*;
#(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned SLOT_BYTES = 32768,
  parameter int unsigned PAGES      = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [31:0] in_key,
  input  wire logic [15:0] in_item_size,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_status,
  output logic [7:0]       out_slot_index,
  output logic [15:0]      out_slot_size,
  output logic [31:0]      out_slot_address,
  output logic [15:0]      out_erase_length,
  output logic [8:0]       out_freed_count,
  output logic             out_header_dirty
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOTS);
  localparam logic [31:0] SLOT_BYTES_W = 32'(SLOT_BYTES);
  localparam logic [31:0] BASE_ADDR = 32'(SECTOR_BYTES * (1 + PAGES));
  localparam logic [16:0] SECTOR_MASK = 17'(SECTOR_BYTES - 1);

  // sequencer and walk counters
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               rv_r, rv_nxt;
  logic [IDX_W-1:0]   ridx_r, ridx_nxt;

  // command held during the walk
  cmd_t               cmd_r, cmd_nxt;
  logic [31:0]        key_r, key_nxt;
  logic [15:0]        size_r, size_nxt;
  logic               bad_r, bad_nxt;

  // walk findings
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [15:0]        hit_size_r, hit_size_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]   freed_r, freed_nxt;

  // result before the output register
  status_t            res_status_r, res_status_nxt;
  logic [IDX_W-1:0]   res_idx_r, res_idx_nxt;
  logic [15:0]        res_size_r, res_size_nxt;
  logic               res_report_r, res_report_nxt;
  logic               res_dirty_r, res_dirty_nxt;
  logic [31:0]        prod_r, prod_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [7:0]         out_slot_index_r, out_slot_index_nxt;
  logic [15:0]        out_slot_size_r, out_slot_size_nxt;
  logic [31:0]        out_slot_address_r, out_slot_address_nxt;
  logic [15:0]        out_erase_length_r, out_erase_length_nxt;
  logic [8:0]         out_freed_count_r, out_freed_count_nxt;
  logic               out_header_dirty_r, out_header_dirty_nxt;

  // slot table
  slot_entry_t        mem [SLOTS];
  slot_entry_t        rdata_r;
  slot_entry_t        mem_wdata;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   mem_raddr;

  logic               in_xfer;
  logic               out_free;
  logic               used;
  logic               key_hit;
  logic               first_hit;
  logic               insert_ok;
  logic [31:0]        res_idx_ext;
  logic [31:0]        freed_ext;
  logic [16:0]        erase_sum;

  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign used      = (rdata_r.size != 16'd0);
  // the one shared comparator: held key against the slot just read
  assign key_hit   = used && (rdata_r.key == key_r) && (key_r != 32'd0);
  assign first_hit = rv_r && key_hit && !found_r;
  assign insert_ok = !bad_r && !found_r && free_found_r;
  assign mem_raddr = cnt_r[IDX_W-1:0];

  assign res_idx_ext = 32'(res_idx_r);
  assign freed_ext   = 32'(freed_r);
  assign erase_sum   = ({1'b0, res_size_r} + SECTOR_MASK) & ~SECTOR_MASK;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_r == LAST_CNT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = bad_nxt ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == LAST_CNT) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // handshake and table write port
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = ridx_r;
    mem_wdata = '0;
    case (state_r)
      ST_CLEAR: begin
        // clearing pass after reset
        mem_we    = (cnt_r != LAST_CNT);
        mem_waddr = cnt_r[IDX_W-1:0];
      end
      ST_SCAN: begin
        if (rv_r && (cmd_r == CMD_MARK) && first_hit) begin
          mem_we    = 1'b1;
          mem_wdata = '{key: rdata_r.key, size: rdata_r.size, mark: 1'b1};
        end else if (rv_r && (cmd_r == CMD_SWEEP)) begin
          // unmarked used slots are freed, every mark is cleared
          mem_we = 1'b1;
          if (used && !rdata_r.mark) begin
            mem_wdata = '0;
          end else begin
            mem_wdata = '{key: rdata_r.key, size: rdata_r.size, mark: 1'b0};
          end
        end
      end
      ST_FIN: begin
        if ((cmd_r == CMD_INSERT) && insert_ok) begin
          mem_we    = 1'b1;
          mem_waddr = free_idx_r;
          mem_wdata = '{key: key_r, size: size_r, mark: 1'b0};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    cnt_nxt        = cnt_r;
    rv_nxt         = 1'b0;
    ridx_nxt       = ridx_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    size_nxt       = size_r;
    bad_nxt        = (in_cmd == CMD_INSERT) &&
                     ((in_key == 32'd0) || (in_item_size == 16'd0) ||
                      (32'(in_item_size) > SLOT_BYTES_W));
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_size_nxt   = hit_size_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    freed_nxt      = freed_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_size_nxt   = res_size_r;
    res_report_nxt = res_report_r;
    res_dirty_nxt  = res_dirty_r;
    prod_nxt       = prod_r;

    out_valid_nxt        = out_valid_r;
    out_status_nxt       = out_status_r;
    out_slot_index_nxt   = out_slot_index_r;
    out_slot_size_nxt    = out_slot_size_r;
    out_slot_address_nxt = out_slot_address_r;
    out_erase_length_nxt = out_erase_length_r;
    out_freed_count_nxt  = out_freed_count_r;
    out_header_dirty_nxt = out_header_dirty_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // findings of the slot read last cycle
    if (first_hit) begin
      found_nxt    = 1'b1;
      hit_idx_nxt  = ridx_r;
      hit_size_nxt = rdata_r.size;
    end
    if (rv_r && !used && !free_found_r) begin
      free_found_nxt = 1'b1;
      free_idx_nxt   = ridx_r;
    end
    if (rv_r && (cmd_r == CMD_SWEEP) && used && !rdata_r.mark) begin
      freed_nxt = freed_r + CNT_W'(1);
    end

    case (state_r)
      ST_CLEAR: begin
        if (cnt_r != LAST_CNT) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_nxt        = cmd_t'(in_cmd);
          key_nxt        = in_key;
          size_nxt       = in_item_size;
          cnt_nxt        = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          freed_nxt      = '0;
        end
      end
      ST_SCAN: begin
        if (cnt_r != LAST_CNT) begin
          rv_nxt   = 1'b1;
          ridx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      ST_FIN: begin
        res_report_nxt = 1'b0;
        res_dirty_nxt  = 1'b0;
        res_idx_nxt    = hit_idx_r;
        res_size_nxt   = hit_size_r;
        case (cmd_r)
          CMD_LOOKUP: begin
            if (found_r) begin
              res_status_nxt = STAT_FOUND;
              res_report_nxt = 1'b1;
            end else begin
              res_status_nxt = STAT_NOT_FOUND;
            end
          end
          CMD_INSERT: begin
            if (bad_r) begin
              res_status_nxt = STAT_INVALID;
            end else if (found_r) begin
              res_status_nxt = STAT_PRESENT;
              res_report_nxt = 1'b1;
            end else if (free_found_r) begin
              res_status_nxt = STAT_INSERTED;
              res_report_nxt = 1'b1;
              res_dirty_nxt  = 1'b1;
              res_idx_nxt    = free_idx_r;
              res_size_nxt   = size_r;
            end else begin
              res_status_nxt = STAT_FULL;
            end
          end
          CMD_MARK: begin
            res_status_nxt = STAT_MARKED;
          end
          default: begin
            if (freed_r != '0) begin
              res_status_nxt = STAT_SWEPT_FREED;
              res_dirty_nxt  = 1'b1;
            end else begin
              res_status_nxt = STAT_SWEPT_NONE;
            end
          end
        endcase
      end
      ST_MUL: begin
        // slot offset in the pool, low 32 bits
        prod_nxt = res_idx_ext * SLOT_BYTES_W;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_status_nxt       = res_status_r;
          out_slot_index_nxt   = res_report_r ? res_idx_ext[7:0] : 8'd0;
          out_slot_size_nxt    = res_report_r ? res_size_r : 16'd0;
          out_slot_address_nxt = res_report_r ? (BASE_ADDR + prod_r) : 32'd0;
          out_erase_length_nxt = res_report_r ? erase_sum[15:0] : 16'd0;
          out_freed_count_nxt  = freed_ext[8:0];
          out_header_dirty_nxt = res_dirty_r;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // slot table storage, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ridx_r             <= ridx_nxt;
    cmd_r              <= cmd_nxt;
    key_r              <= key_nxt;
    size_r             <= size_nxt;
    bad_r              <= (state_r == ST_IDLE) ? bad_nxt : bad_r;
    found_r            <= found_nxt;
    hit_idx_r          <= hit_idx_nxt;
    hit_size_r         <= hit_size_nxt;
    free_found_r       <= free_found_nxt;
    free_idx_r         <= free_idx_nxt;
    freed_r            <= freed_nxt;
    res_status_r       <= res_status_nxt;
    res_idx_r          <= res_idx_nxt;
    res_size_r         <= res_size_nxt;
    res_report_r       <= res_report_nxt;
    res_dirty_r        <= res_dirty_nxt;
    prod_r             <= prod_nxt;
    out_status_r       <= out_status_nxt;
    out_slot_index_r   <= out_slot_index_nxt;
    out_slot_size_r    <= out_slot_size_nxt;
    out_slot_address_r <= out_slot_address_nxt;
    out_erase_length_r <= out_erase_length_nxt;
    out_freed_count_r  <= out_freed_count_nxt;
    out_header_dirty_r <= out_header_dirty_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot_index   = out_slot_index_r;
  assign out_slot_size    = out_slot_size_r;
  assign out_slot_address = out_slot_address_r;
  assign out_erase_length = out_erase_length_r;
  assign out_freed_count  = out_freed_count_r;
  assign out_header_dirty = out_header_dirty_r;

  // checks
  `CKSA_ASSERT(a_xfer_starts_work, clk, rst_n, in_xfer |=> (state_r == ST_SCAN || state_r == ST_FIN), "transfer did not start a walk")
  `CKSA_ASSERT(a_result_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_DONE), "result appeared outside the done step")
  `CKSA_ASSERT(a_no_write_idle, clk, rst_n, (state_r == ST_IDLE || state_r == ST_DONE) |-> !mem_we, "table written while no command runs")
  `CKSA_ASSERT(a_insert_dirty, clk, rst_n, (out_valid_r && out_status_r == STAT_INSERTED) |-> out_header_dirty_r, "insert without dirty header")
  `CKSA_ASSERT_ALWAYS(a_clear_no_result, clk, (rst_n && state_r == ST_CLEAR) |-> !out_valid_r, "result during clearing pass")

endmodule

`default_nettype wire
